[sv/llsp_pkg.sv]
package llsp_pkg;

    // Default sizes of the block
    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_MAX_ROWS      = 2048;
    localparam int DEF_FRACTION_BITS = 8;

    // Fixed field widths
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 10;
    localparam int THR_W     = 10;
    localparam int ROW_OUT_W = 11;
    localparam int POS_W     = 19;

    localparam logic [THR_W-1:0] THR_RESET = 10'd128;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } llsp_state_t;

    // What the row tracker hands over at row end
    typedef struct packed {
        logic             found;
        logic [SUM_W-1:0] left_sum;
        logic [SUM_W-1:0] right_sum;
    } llsp_summary_t;

endpackage

[sv/llsp_if.sv]
// Pixel channel
interface llsp_pix_if;
    logic                          valid;
    logic                          ready;
    logic [llsp_pkg::PIX_W-1:0]    blue;
    logic [llsp_pkg::PIX_W-1:0]    green;
    logic [llsp_pkg::PIX_W-1:0]    red;
    logic                          row_end;
    logic                          frame_end;

    modport source (
        output valid, blue, green, red, row_end, frame_end,
        input  ready
    );
    modport sink (
        input  valid, blue, green, red, row_end, frame_end,
        output ready
    );
endinterface

// Result channel
interface llsp_res_if;
    logic                              valid;
    logic                              ready;
    logic [llsp_pkg::ROW_OUT_W-1:0]    row_index;
    logic                              line_found;
    logic [llsp_pkg::POS_W-1:0]        position;

    modport source (
        output valid, row_index, line_found, position,
        input  ready
    );
    modport sink (
        input  valid, row_index, line_found, position,
        output ready
    );
endinterface

[sv/llsp_tracker.sv]
module llsp_tracker #(
    parameter int MAX_WIDTH = llsp_pkg::DEF_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [llsp_pkg::PIX_W-1:0]    blue,
    input  logic [llsp_pkg::PIX_W-1:0]    green,
    input  logic [llsp_pkg::PIX_W-1:0]    red,
    input  logic                          end_row,
    input  logic [llsp_pkg::THR_W-1:0]    threshold,
    output llsp_pkg::llsp_summary_t       summary,
    output logic [COL_W-1:0]              column
);

    localparam int SW = llsp_pkg::SUM_W;

    logic [SW-1:0]    best_sum_reg, best_sum_next;
    logic [COL_W-1:0] best_col_reg, best_col_next;
    logic             best_valid_reg, best_valid_next;
    logic [SW-1:0]    left_reg, left_next;
    logic [SW-1:0]    right_reg, right_next;
    logic             pending_reg, pending_next;
    logic [SW-1:0]    prev_reg, prev_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic             full_reg, full_next;
    logic [SW-1:0]    sum;

    // brightness of the incoming pixel
    assign sum = SW'(blue) + SW'(green) + SW'(red);

    // state after taking this pixel
    always_comb
    begin
        best_sum_next   = best_sum_reg;
        best_col_next   = best_col_reg;
        best_valid_next = best_valid_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        pending_next    = pending_reg;
        prev_next       = prev_reg;
        col_cnt_next    = col_cnt_reg;
        full_next       = full_reg;
        if (fire && !full_reg)
        begin
            if (pending_reg)
            begin
                right_next   = sum;
                pending_next = 1'b0;
            end
            if (sum > best_sum_reg)
            begin
                best_sum_next   = sum;
                best_col_next   = col_cnt_reg;
                best_valid_next = 1'b1;
                left_next       = (col_cnt_reg != '0) ? prev_reg : '0;
                right_next      = '0;
                pending_next    = 1'b1;
            end
            prev_next = sum;
            if (32'(col_cnt_reg) + 32'd1 >= 32'(MAX_WIDTH))
                full_next = 1'b1;
            else
                col_cnt_next = col_cnt_reg + COL_W'(1);
        end
    end

    // row summary as seen after the row-end pixel
    always_comb
    begin
        summary.found     = best_valid_next && (best_sum_next >= threshold);
        summary.left_sum  = left_next;
        summary.right_sum = pending_next ? '0 : right_next;
        column            = best_col_next;
    end

    // row state; a row end clears everything
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg   <= '0;
            best_col_reg   <= '0;
            best_valid_reg <= 1'b0;
            left_reg       <= '0;
            right_reg      <= '0;
            pending_reg    <= 1'b0;
            prev_reg       <= '0;
            col_cnt_reg    <= '0;
            full_reg       <= 1'b0;
        end
        else if (fire)
        begin
            if (end_row)
            begin
                best_sum_reg   <= '0;
                best_col_reg   <= '0;
                best_valid_reg <= 1'b0;
                left_reg       <= '0;
                right_reg      <= '0;
                pending_reg    <= 1'b0;
                prev_reg       <= '0;
                col_cnt_reg    <= '0;
                full_reg       <= 1'b0;
            end
            else
            begin
                best_sum_reg   <= best_sum_next;
                best_col_reg   <= best_col_next;
                best_valid_reg <= best_valid_next;
                left_reg       <= left_next;
                right_reg      <= right_next;
                pending_reg    <= pending_next;
                prev_reg       <= prev_next;
                col_cnt_reg    <= col_cnt_next;
                full_reg       <= full_next;
            end
        end
    end

endmodule

[sv/llsp_divider.sv]
// Restoring divider: right / (left + right), one fraction bit per cycle.
// The numerator never exceeds the denominator, so only fraction bits are formed.
module llsp_divider #(
    parameter int FRACTION_BITS = llsp_pkg::DEF_FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [llsp_pkg::SUM_W-1:0]    numer,
    input  logic [llsp_pkg::SUM_W:0]      denom,
    output logic                          done,
    output logic [FRACTION_BITS-1:0]      quotient
);

    localparam int DW  = llsp_pkg::SUM_W + 1;
    localparam int CNW = $clog2(FRACTION_BITS + 1);

    logic [DW-1:0]            rem_reg, rem_next;
    logic [DW-1:0]            den_reg;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    logic [CNW-1:0]           cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [DW:0]              trial;
    logic                     take;

    // one compare-and-subtract step
    assign trial = {rem_reg, 1'b0};
    assign take  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = DW'(numer);
            cnt_next = CNW'(FRACTION_BITS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = take ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            quo_next  = FRACTION_BITS'({quo_reg, take});
            cnt_next  = cnt_reg - CNW'(1);
            done_next = (cnt_reg == CNW'(1));
        end
    end

    // iteration counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            den_reg <= denom;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/laser_line_subpixel_peak.sv]
// Channel   Dir  Fields                                   Transfer
// pixel     in   blue, green, red, row_end, frame_end      valid & ready
// result    out  row_index, line_found, position           valid & ready
// cfg       in   cfg_wr_data (line_threshold)              cfg_wr_en
//
// A pixel without a row end does not stall the input. A row-end pixel holds the
// input while the shared restoring divider forms one fraction bit per cycle,
// then the result goes to the output register once that register is free.
// Pixels of the next row are taken while a result waits at the output; after
// the next row end the input stays stalled until that result has been transferred.
// Reset clears the row tracking state, the row count and sets the threshold to 128.
module laser_line_subpixel_peak #(
    parameter int MAX_WIDTH     = llsp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS      = llsp_pkg::DEF_MAX_ROWS,
    parameter int FRACTION_BITS = llsp_pkg::DEF_FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    llsp_pix_if.sink                      pixel,
    llsp_res_if.source                    result,
    input  logic                          cfg_wr_en,
    input  logic [llsp_pkg::THR_W-1:0]    cfg_wr_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SW    = llsp_pkg::SUM_W;

    llsp_pkg::llsp_state_t      state_reg, state_next;
    logic [llsp_pkg::THR_W-1:0] thr_reg;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic                       fire, end_row;
    llsp_pkg::llsp_summary_t    summary, sum_reg;
    logic [COL_W-1:0]           column, col_reg;
    logic [ROW_W-1:0]           row_snap_reg;
    logic                       div_done;
    logic [FRACTION_BITS-1:0]   quotient;
    logic                       load;
    logic                       out_valid_reg, out_valid_next;
    logic [llsp_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic                       out_found_reg;
    logic [llsp_pkg::POS_W-1:0] out_pos_reg;
    logic [31:0]                row_wide, pos_base, pos_half, pos_calc;

    assign fire        = pixel.valid && pixel.ready;
    assign end_row     = pixel.row_end || pixel.frame_end;
    assign pixel.ready = (state_reg == llsp_pkg::ST_IDLE);

    // per-pixel tracking of the row maximum
    llsp_tracker #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .blue      (pixel.blue),
        .green     (pixel.green),
        .red       (pixel.red),
        .end_row   (end_row),
        .threshold (thr_reg),
        .summary   (summary),
        .column    (column)
    );

    // shared divider for the sub-pixel fraction
    llsp_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fire && end_row),
        .numer    (summary.right_sum),
        .denom    ((SW + 1)'(summary.left_sum) + (SW + 1)'(summary.right_sum)),
        .done     (div_done),
        .quotient (quotient)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            llsp_pkg::ST_IDLE:
                if (fire && end_row)
                    state_next = llsp_pkg::ST_DIV;
            llsp_pkg::ST_DIV:
                if (div_done)
                    state_next = llsp_pkg::ST_LOAD;
            llsp_pkg::ST_LOAD:
                if (!out_valid_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = llsp_pkg::ST_IDLE;
                end
            default:
                state_next = llsp_pkg::ST_IDLE;
        endcase
    end

    // row counter, wraps at MAX_ROWS or on frame end
    always_comb
    begin
        row_next = row_reg;
        if (fire && end_row)
        begin
            if (pixel.frame_end || (32'(row_reg) + 32'd1 >= 32'(MAX_ROWS)))
                row_next = '0;
            else
                row_next = row_reg + ROW_W'(1);
        end
    end

    // position from column and fraction
    always_comb
    begin
        row_wide = 32'(row_snap_reg);
        pos_base = 32'(col_reg) << FRACTION_BITS;
        pos_half = 32'd1 << (FRACTION_BITS - 1);
        pos_calc = '0;
        if (sum_reg.found)
        begin
            if (sum_reg.left_sum != '0 && sum_reg.right_sum != '0)
                pos_calc = pos_base - pos_half + 32'(quotient);
            else
                pos_calc = pos_base;
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llsp_pkg::ST_IDLE;
            thr_reg       <= llsp_pkg::THR_RESET;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
        end
    end

    // row snapshot and result payload
    always_ff @(posedge clk)
    begin
        if (fire && end_row)
        begin
            sum_reg      <= summary;
            col_reg      <= column;
            row_snap_reg <= row_reg;
        end
        if (load)
        begin
            out_row_reg   <= row_wide[llsp_pkg::ROW_OUT_W-1:0];
            out_found_reg <= sum_reg.found;
            out_pos_reg   <= pos_calc[llsp_pkg::POS_W-1:0];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.row_index  = out_row_reg;
    assign result.line_found = out_found_reg;
    assign result.position   = out_pos_reg;

endmodule

[tb/sv/laser_line_subpixel_peak_test.sv]
`timescale 1ns / 1ps

module laser_line_subpixel_peak_test;

    localparam int MAX_WIDTH    = llsp_pkg::DEF_MAX_WIDTH;
    localparam int MAX_ROWS     = llsp_pkg::DEF_MAX_ROWS;
    localparam int FRAC_BITS    = llsp_pkg::DEF_FRACTION_BITS;
    localparam int PIX_W        = llsp_pkg::PIX_W;
    localparam int THR_W        = llsp_pkg::THR_W;
    localparam int ROW_OUT_W    = llsp_pkg::ROW_OUT_W;
    localparam int POS_W        = llsp_pkg::POS_W;
    localparam int MAX_SUM      = 765;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    // margin for the hold of the pixel input after a row end while the divider runs
    localparam int DIV_LATENCY  = 2 * (FRAC_BITS + 3) + 4;
    localparam int RANDOM_CHUNK = 180;
    localparam int RANDOM_PHASES = 4;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             row_end;
        logic             frame_end;
    } pixel_item_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row_index;
        logic                 line_found;
        logic [POS_W-1:0]     position;
    } line_result_t;

    typedef enum int {
        ROW_LASER,
        ROW_NOISE,
        ROW_FLAT,
        ROW_DARK
    } row_style_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    llsp_pix_if pix_bus ();
    llsp_res_if line_bus ();

    laser_line_subpixel_peak #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRAC_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pix_bus),
        .result      (line_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #CLK_HALF clk = ~clk;

    // Stimulus and expectation stores
    pixel_item_t  pending_pixels[$];
    line_result_t expected_lines[$];
    int           queued_px   = 0;
    int           accepted_px = 0;
    int           fail_count  = 0;
    bit           idle_on     = 1'b1;

    pixel_item_t  cur_px;
    int           gap_left   = 0;
    int           stall_left = 0;

    // Mirror of the row tracker
    int line_thr = int'(llsp_pkg::THR_RESET);
    int peak_sum;
    int peak_col;
    int left_nb;
    int right_nb;
    int prev_sum;
    int col_cnt;
    int row_cnt = 0;
    bit peak_seen;
    bit right_wait;
    bit row_full;

    function automatic void clear_row_track();
        peak_sum   = 0;
        peak_col   = 0;
        peak_seen  = 1'b0;
        left_nb    = 0;
        right_nb   = 0;
        right_wait = 1'b0;
        prev_sum   = 0;
        col_cnt    = 0;
        row_full   = 1'b0;
    endfunction

    // Update the row tracker with one pixel; a row end yields the expected line
    function automatic void track_pixel(pixel_item_t px);
        int           sum;
        int           right_eff;
        longint       pos;
        line_result_t res;
        sum = int'(px.blue) + int'(px.green) + int'(px.red);
        // pixels past the row width neither win nor act as neighbour
        if (!row_full)
        begin
            if (right_wait)
            begin
                right_nb   = sum;
                right_wait = 1'b0;
            end
            if (sum > peak_sum)
            begin
                peak_sum   = sum;
                peak_col   = col_cnt;
                peak_seen  = 1'b1;
                left_nb    = (col_cnt > 0) ? prev_sum : 0;
                right_nb   = 0;
                right_wait = 1'b1;
            end
            prev_sum = sum;
            if (col_cnt + 1 >= MAX_WIDTH)
                row_full = 1'b1;
            else
                col_cnt++;
        end
        if (px.row_end || px.frame_end)
        begin
            right_eff      = right_wait ? 0 : right_nb;
            pos            = 0;
            res.line_found = peak_seen && (peak_sum >= line_thr);
            if (res.line_found)
            begin
                pos = longint'(peak_col) << FRAC_BITS;
                // centre of gravity between the neighbours, only with both present
                if (left_nb != 0 && right_eff != 0)
                    pos = pos - (longint'(1) << (FRAC_BITS - 1))
                        + ((longint'(right_eff) << FRAC_BITS) / longint'(left_nb + right_eff));
            end
            res.row_index = ROW_OUT_W'(row_cnt);
            res.position  = POS_W'(pos);
            expected_lines.push_back(res);
            clear_row_track();
            if (px.frame_end || row_cnt + 1 >= MAX_ROWS)
                row_cnt = 0;
            else
                row_cnt++;
        end
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Pixel with the given brightness, split at random over the three bytes
    function automatic pixel_item_t make_pixel(int s, bit re, bit fe);
        pixel_item_t px;
        int          lvl;
        int          b;
        int          g;
        int          rest;
        lvl          = (s > MAX_SUM) ? MAX_SUM : ((s < 0) ? 0 : s);
        b            = $urandom_range((lvl > 510) ? lvl - 510 : 0, (lvl < 255) ? lvl : 255);
        rest         = lvl - b;
        g            = $urandom_range((rest > 255) ? rest - 255 : 0, (rest < 255) ? rest : 255);
        px.blue      = PIX_W'(b);
        px.green     = PIX_W'(g);
        px.red       = PIX_W'(rest - g);
        px.row_end   = re;
        px.frame_end = fe;
        return px;
    endfunction

    function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic queue_pixel(pixel_item_t px);
        pending_pixels.push_back(px);
        queued_px++;
    endtask

    task automatic queue_bytes(int b, int g, int r, bit re, bit fe);
        pixel_item_t px;
        px.blue      = PIX_W'(b);
        px.green     = PIX_W'(g);
        px.red       = PIX_W'(r);
        px.row_end   = re;
        px.frame_end = fe;
        queue_pixel(px);
    endtask

    task automatic queue_sum(int s, bit re, bit fe);
        queue_pixel(make_pixel(s, re, fe));
    endtask

    // One camera row with random content in the given shape
    task automatic queue_row(int len, row_style_t style, bit fe);
        int peak_at;
        int peak_lvl;
        int bg_max;
        int s;
        bit last_re;
        peak_at  = $urandom_range(0, len - 1);
        peak_lvl = $urandom_range(150, MAX_SUM);
        bg_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        // a frame end closes the row with or without its own row end
        last_re  = fe ? 1'($urandom_range(0, 1)) : 1'b1;
        for (int c = 0; c < len; c++)
        begin
            case (style)
                ROW_LASER:
                begin
                    if (c == peak_at)
                        s = peak_lvl;
                    else if (c == peak_at - 1 || c == peak_at + 1)
                        s = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, peak_lvl);
                    else
                        s = $urandom_range(0, bg_max);
                end
                ROW_NOISE: s = $urandom_range(0, MAX_SUM);
                ROW_FLAT:  s = ($urandom_range(0, 2) == 0) ? $urandom_range(0, peak_lvl) : peak_lvl;
                default:   s = 0;
            endcase
            queue_sum(s, (c == len - 1) && last_re, (c == len - 1) && fe);
        end
    endtask

    // Wait until every pixel is taken and every line has come back
    task automatic drain_pipe();
        while (accepted_px != queued_px || expected_lines.size() != 0)
            @(negedge clk);
        repeat (DIV_LATENCY) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        line_thr    = int'(v);
        @(negedge clk);
    endtask

    // Pixel driver: presents queued pixels, predicts on each transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_bus.valid <= 1'b0;
            gap_left      = 0;
        end
        else
        begin
            if (pix_bus.valid && pix_bus.ready)
            begin
                track_pixel(cur_px);
                accepted_px++;
            end
            if (pix_bus.valid && !pix_bus.ready)
            begin
                // hold the pixel until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                pix_bus.valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                cur_px = pending_pixels.pop_front();
                pix_bus.blue      <= cur_px.blue;
                pix_bus.green     <= cur_px.green;
                pix_bus.red       <= cur_px.red;
                pix_bus.row_end   <= cur_px.row_end;
                pix_bus.frame_end <= cur_px.frame_end;
                pix_bus.valid     <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 30)
                    gap_left = idle_len();
            end
            else
                pix_bus.valid <= 1'b0;
        end
    end

    // Result monitor: random back-pressure, compare each transfer in order
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            line_bus.ready <= 1'b0;
            stall_left     = 0;
        end
        else
        begin
            if (line_bus.valid && line_bus.ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: unexpected line: expected none, actual row %0d found %0b pos %0d",
                             $time, line_bus.row_index, line_bus.line_found, line_bus.position);
                    fail_count++;
                end
                else
                begin
                    check_field("row_index", 32'(expected_lines[0].row_index),
                                32'(line_bus.row_index));
                    check_field("line_found", 32'(expected_lines[0].line_found),
                                32'(line_bus.line_found));
                    check_field("position", 32'(expected_lines[0].position),
                                32'(line_bus.position));
                    void'(expected_lines.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                line_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_len() - 1;
                line_bus.ready <= 1'b0;
            end
            else
                line_bus.ready <= 1'b1;
        end
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        int         chunk_items;
        int         len;
        int         r;
        row_style_t style;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        pix_bus.valid      = 1'b0;
        pix_bus.blue       = '0;
        pix_bus.green      = '0;
        pix_bus.red        = '0;
        pix_bus.row_end    = 1'b0;
        pix_bus.frame_end  = 1'b0;
        line_bus.ready     = 1'b0;
        clear_row_track();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows at the reset threshold
        queue_bytes(255, 255, 255, 1'b1, 1'b0);
        // each byte alone at full scale; tie keeps the first
        queue_bytes(0, 0, 0, 1'b0, 1'b0);
        queue_bytes(255, 0, 0, 1'b0, 1'b0);
        queue_bytes(0, 255, 0, 1'b0, 1'b0);
        queue_bytes(0, 0, 255, 1'b1, 1'b0);
        // both neighbours present: refined position
        queue_sum(100, 1'b0, 1'b0);
        queue_sum(765, 1'b0, 1'b0);
        queue_sum(200, 1'b1, 1'b0);
        // maximum in the first column
        queue_sum(600, 1'b0, 1'b0);
        queue_sum(300, 1'b1, 1'b0);
        // row ends before the right neighbour
        queue_sum(50, 1'b0, 1'b0);
        queue_sum(700, 1'b1, 1'b0);
        // dark row
        queue_sum(0, 1'b0, 1'b0);
        queue_sum(0, 1'b1, 1'b0);
        // equal maxima, zero right neighbour of the last
        queue_sum(300, 1'b0, 1'b0);
        queue_sum(500, 1'b0, 1'b0);
        queue_sum(500, 1'b0, 1'b0);
        queue_sum(0, 1'b1, 1'b0);
        // just below and exactly at the threshold
        queue_sum(10, 1'b0, 1'b0);
        queue_sum(127, 1'b0, 1'b0);
        queue_sum(10, 1'b1, 1'b0);
        queue_sum(128, 1'b1, 1'b0);
        // frame end alone closes the row, then both marks together
        queue_sum(0, 1'b0, 1'b0);
        queue_sum(40, 1'b0, 1'b0);
        queue_sum(200, 1'b0, 1'b0);
        queue_sum(40, 1'b0, 1'b1);
        queue_sum(90, 1'b1, 1'b1);

        // Zero threshold: a dark row still has no line
        drain_pipe();
        write_threshold(THR_W'(0));
        queue_sum(0, 1'b1, 1'b0);
        queue_sum(1, 1'b1, 1'b0);

        // Threshold beyond the largest sum
        drain_pipe();
        write_threshold(THR_W'(1023));
        queue_sum(765, 1'b1, 1'b0);

        // Threshold at the largest sum
        drain_pipe();
        write_threshold(THR_W'(MAX_SUM));
        queue_sum(765, 1'b1, 1'b0);
        queue_sum(764, 1'b1, 1'b0);

        // Random rows, mostly laser-shaped, one threshold per phase;
        // the last phase runs at full rate on both sides
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            drain_pipe();
            if (k == 1)
                write_threshold(THR_W'($urandom_range(0, 1023)));
            else
                write_threshold(THR_W'($urandom_range(40, 500)));
            idle_on = (k != RANDOM_PHASES - 1);
            chunk_items = 0;
            while (chunk_items < RANDOM_CHUNK)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 20);
                r   = $urandom_range(0, 99);
                if (r < 70)
                    style = ROW_LASER;
                else if (r < 85)
                    style = ROW_NOISE;
                else if (r < 93)
                    style = ROW_FLAT;
                else
                    style = ROW_DARK;
                queue_row(len, style, $urandom_range(0, 11) == 0);
                chunk_items += len;
            end
        end

        drain_pipe();
        if (fail_count == 0 && expected_lines.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/llsp_pkg.sv
sv/llsp_if.sv
sv/llsp_tracker.sv
sv/llsp_divider.sv
sv/laser_line_subpixel_peak.sv
tb/sv/laser_line_subpixel_peak_test.sv
